/* rtl/rle_signed_command_encoder_defines.svh */
// Assertion macros for the run-length encoder.
// Included by the top level; needs nothing else.
`ifndef RLE_SIGNED_COMMAND_ENCODER_DEFINES_SVH
`define RLE_SIGNED_COMMAND_ENCODER_DEFINES_SVH

// same-cycle implication
`define RLE_ASSERT_IMP(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication
`define RLE_ASSERT_NXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

/* rtl/rle_enc_pkg.sv */
// Shared types and constants of the run-length encoder.
// No dependencies.
package rle_enc_pkg;

   localparam int LIT_DEPTH  = 256;
   localparam int LIT_AW     = $clog2(LIT_DEPTH);
   localparam int BYTE_W     = 8;
   localparam int RUN_W      = 7;
   localparam int WORD_BYTES = 8;
   localparam int LANE_AW    = $clog2(WORD_BYTES);
   localparam int VB_W       = 4;

   localparam logic [RUN_W-1:0] THRESH_RESET = 7'd2;

   // what follows a chunk decision
   localparam logic [1:0] MODE_OVERFLOW   = 2'd0;
   localparam logic [1:0] MODE_PRE_REPEAT = 2'd1;
   localparam logic [1:0] MODE_FINAL      = 2'd2;

   typedef struct packed {
      logic              byte_valid;
      logic [BYTE_W-1:0] data;
      logic              step_end;
      logic              stream_end;
   } pk_cmd_type;

   typedef struct packed {
      logic              idle;
      logic [LIT_AW-1:0] pending;
      logic [RUN_W-1:0]  run_len;
   } seq_status_type;

endpackage

/* rtl/rle_enc_ram.sv */
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module rle_enc_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 256
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      // hold read data when no read is issued
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

/* rtl/rle_enc_seq.sv */
// Byte sequencer: run tracking, literal store writes and read-back, chunk and
// repeat emission. Depends on rle_enc_pkg; drives the literal store RAM.
module rle_enc_seq #(
   parameter int MAX_RUN   = 127,
   parameter int MAX_CHUNK = 128
) (
   input  logic                                     clock,
   input  logic                                     reset,
   input  logic                                     req_valid,
   input  logic [rle_enc_pkg::BYTE_W-1:0]           req_data_byte,
   input  logic                                     req_final_byte,
   input  logic [rle_enc_pkg::RUN_W-1:0]            threshold,
   output rle_enc_pkg::seq_status_type              status,
   output rle_enc_pkg::pk_cmd_type                  pk_cmd,
   input  logic                                     pk_ready,
   output logic                                     ram_wr_en,
   output logic [rle_enc_pkg::LIT_AW-1:0]           ram_wr_addr,
   output logic [rle_enc_pkg::BYTE_W-1:0]           ram_wr_data,
   output logic                                     ram_rd_en,
   output logic [rle_enc_pkg::LIT_AW-1:0]           ram_rd_addr,
   input  logic [rle_enc_pkg::BYTE_W-1:0]           ram_rd_data
);

   import rle_enc_pkg::*;

   localparam logic [3:0] ST_IDLE       = 4'd0;
   localparam logic [3:0] ST_CLOSE      = 4'd1;
   localparam logic [3:0] ST_APPEND     = 4'd2;
   localparam logic [3:0] ST_CHUNK_END  = 4'd3;
   localparam logic [3:0] ST_CHUNK_CMD  = 4'd4;
   localparam logic [3:0] ST_CHUNK_DATA = 4'd5;
   localparam logic [3:0] ST_REP_CNT    = 4'd6;
   localparam logic [3:0] ST_REP_VAL    = 4'd7;
   localparam logic [3:0] ST_AFTER      = 4'd8;
   localparam logic [3:0] ST_END_ZERO   = 4'd9;
   localparam logic [3:0] ST_DONE       = 4'd10;

   localparam logic [RUN_W-1:0]  RUN_MAX   = RUN_W'(MAX_RUN);
   localparam logic [LIT_AW-1:0] CHUNK_MAX = LIT_AW'(MAX_CHUNK);

   logic [3:0]        state_ff, state_in;
   logic              fin_ff, fin_in;
   logic              final_phase_ff, final_phase_in;
   logic [1:0]        mode_ff, mode_in;
   logic [RUN_W-1:0]  cl_len_ff, cl_len_in;
   logic [BYTE_W-1:0] cl_val_ff, cl_val_in;
   logic [RUN_W-1:0]  run_len_ff, run_len_in;
   logic [BYTE_W-1:0] run_val_ff, run_val_in;
   logic [LIT_AW-1:0] head_ff, head_in;
   logic [LIT_AW-1:0] pend_ff, pend_in;
   logic [LIT_AW-1:0] chunk_cnt_ff, chunk_cnt_in;

   logic              extend;
   logic [LIT_AW-1:0] chunk_n;

   assign extend  = (run_len_ff != '0) && (req_data_byte == run_val_ff) &&
                    (run_len_ff < RUN_MAX);
   assign chunk_n = (pend_ff < CHUNK_MAX) ? pend_ff : CHUNK_MAX;

   always_comb begin
      state_in       = state_ff;
      fin_in         = fin_ff;
      final_phase_in = final_phase_ff;
      mode_in        = mode_ff;
      cl_len_in      = cl_len_ff;
      cl_val_in      = cl_val_ff;
      run_len_in     = run_len_ff;
      run_val_in     = run_val_ff;
      head_in        = head_ff;
      pend_in        = pend_ff;
      chunk_cnt_in   = chunk_cnt_ff;
      pk_cmd         = '0;
      ram_wr_en      = 1'b0;
      ram_wr_addr    = head_ff + pend_ff;
      ram_wr_data    = cl_val_ff;
      ram_rd_en      = 1'b0;
      ram_rd_addr    = head_ff;

      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               fin_in         = req_final_byte;
               final_phase_in = 1'b0;
               if (extend) begin
                  run_len_in = run_len_ff + RUN_W'(1);
                  cl_len_in  = '0;
               end else begin
                  cl_len_in  = run_len_ff;
                  cl_val_in  = run_val_ff;
                  run_val_in = req_data_byte;
                  run_len_in = RUN_W'(1);
               end
               // a growing run with no stream end produces nothing
               if (req_final_byte || (!extend && run_len_ff != '0)) begin
                  state_in = ST_CLOSE;
               end
            end
         end
         ST_CLOSE: begin
            if (cl_len_ff == '0) begin
               state_in = ST_AFTER;
            end else if (cl_len_ff > threshold) begin
               mode_in  = MODE_PRE_REPEAT;
               state_in = ST_CHUNK_END;
            end else begin
               state_in = ST_APPEND;
            end
         end
         ST_APPEND: begin
            ram_wr_en = 1'b1;
            pend_in   = pend_ff + LIT_AW'(1);
            cl_len_in = cl_len_ff - RUN_W'(1);
            if (cl_len_ff == RUN_W'(1)) begin
               mode_in  = MODE_OVERFLOW;
               state_in = ST_CHUNK_END;
            end
         end
         ST_CHUNK_END: begin
            case (mode_ff)
               MODE_OVERFLOW: begin
                  state_in = (pend_ff >= CHUNK_MAX) ? ST_CHUNK_CMD : ST_AFTER;
               end
               MODE_PRE_REPEAT: begin
                  state_in = (pend_ff != '0) ? ST_CHUNK_CMD : ST_REP_CNT;
               end
               MODE_FINAL: begin
                  state_in = (pend_ff != '0) ? ST_CHUNK_CMD : ST_END_ZERO;
               end
               default: begin
                  state_in = ST_AFTER;
               end
            endcase
         end
         ST_CHUNK_CMD: begin
            pk_cmd.byte_valid = 1'b1;
            pk_cmd.data       = BYTE_W'(LIT_AW'(0) - chunk_n);
            if (pk_ready) begin
               chunk_cnt_in = chunk_n;
               ram_rd_en    = 1'b1;
               state_in     = ST_CHUNK_DATA;
            end
         end
         ST_CHUNK_DATA: begin
            pk_cmd.byte_valid = 1'b1;
            pk_cmd.data       = ram_rd_data;
            if (pk_ready) begin
               head_in      = head_ff + LIT_AW'(1);
               pend_in      = pend_ff - LIT_AW'(1);
               chunk_cnt_in = chunk_cnt_ff - LIT_AW'(1);
               if (chunk_cnt_ff == LIT_AW'(1)) begin
                  state_in = ST_CHUNK_END;
               end else begin
                  // prefetch the next literal while this one is taken
                  ram_rd_en   = 1'b1;
                  ram_rd_addr = head_ff + LIT_AW'(1);
               end
            end
         end
         ST_REP_CNT: begin
            pk_cmd.byte_valid = 1'b1;
            pk_cmd.data       = {1'b0, cl_len_ff};
            if (pk_ready) begin
               state_in = ST_REP_VAL;
            end
         end
         ST_REP_VAL: begin
            pk_cmd.byte_valid = 1'b1;
            pk_cmd.data       = cl_val_ff;
            if (pk_ready) begin
               state_in = ST_AFTER;
            end
         end
         ST_AFTER: begin
            if (final_phase_ff) begin
               mode_in  = MODE_FINAL;
               state_in = ST_CHUNK_END;
            end else if (fin_ff) begin
               // close the open run and clear run state for the next stream
               cl_len_in      = run_len_ff;
               cl_val_in      = run_val_ff;
               run_len_in     = '0;
               run_val_in     = '0;
               final_phase_in = 1'b1;
               state_in       = ST_CLOSE;
            end else begin
               state_in = ST_DONE;
            end
         end
         ST_END_ZERO: begin
            pk_cmd.byte_valid = 1'b1;
            pk_cmd.data       = '0;
            if (pk_ready) begin
               state_in = ST_DONE;
            end
         end
         ST_DONE: begin
            pk_cmd.step_end   = 1'b1;
            pk_cmd.stream_end = fin_ff;
            if (pk_ready) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= ST_IDLE;
         fin_ff         <= 1'b0;
         final_phase_ff <= 1'b0;
         mode_ff        <= MODE_OVERFLOW;
         run_len_ff     <= '0;
         run_val_ff     <= '0;
         head_ff        <= '0;
         pend_ff        <= '0;
      end else begin
         state_ff       <= state_in;
         fin_ff         <= fin_in;
         final_phase_ff <= final_phase_in;
         mode_ff        <= mode_in;
         run_len_ff     <= run_len_in;
         run_val_ff     <= run_val_in;
         head_ff        <= head_in;
         pend_ff        <= pend_in;
      end
   end

   always_ff @(posedge clock) begin
      cl_len_ff    <= cl_len_in;
      cl_val_ff    <= cl_val_in;
      chunk_cnt_ff <= chunk_cnt_in;
   end

   assign status.idle    = (state_ff == ST_IDLE);
   assign status.pending = pend_ff;
   assign status.run_len = run_len_ff;

endmodule

/* rtl/rle_enc_pack.sv */
// Byte packer: gathers up to eight bytes per result and holds the result
// register toward the output channel. Depends on rle_enc_pkg.
module rle_enc_pack (
   input  logic                                             clock,
   input  logic                                             reset,
   input  rle_enc_pkg::pk_cmd_type                          pk_cmd,
   output logic                                             pk_ready,
   output logic                                             rsp_valid,
   input  logic                                             rsp_stall,
   output logic [rle_enc_pkg::WORD_BYTES*rle_enc_pkg::BYTE_W-1:0] rsp_packed_bytes,
   output logic [rle_enc_pkg::VB_W-1:0]                     rsp_valid_bytes,
   output logic                                             rsp_run_last,
   output logic                                             rsp_stream_end
);

   import rle_enc_pkg::*;

   logic [WORD_BYTES-1:0][BYTE_W-1:0] acc_ff, acc_in;
   logic [VB_W-1:0]                   cnt_ff, cnt_in;
   logic                              rsp_valid_ff;
   logic [WORD_BYTES*BYTE_W-1:0]      rsp_data_ff;
   logic [VB_W-1:0]                   rsp_vb_ff;
   logic                              rsp_last_ff;
   logic                              rsp_end_ff;

   logic full;
   logic out_free;
   logic need_push;
   logic do_push;
   logic push_is_end;

   assign full        = (cnt_ff == VB_W'(WORD_BYTES));
   assign out_free    = !rsp_valid_ff || !rsp_stall;
   assign push_is_end = pk_cmd.step_end && (cnt_ff != '0);
   assign need_push   = (pk_cmd.byte_valid && full) || push_is_end;
   assign pk_ready    = need_push ? out_free : 1'b1;
   assign do_push     = need_push && out_free;

   always_comb begin
      acc_in = acc_ff;
      cnt_in = cnt_ff;
      if (pk_cmd.byte_valid && pk_ready) begin
         if (full) begin
            acc_in    = '0;
            acc_in[0] = pk_cmd.data;
            cnt_in    = VB_W'(1);
         end else begin
            acc_in[cnt_ff[LANE_AW-1:0]] = pk_cmd.data;
            cnt_in = cnt_ff + VB_W'(1);
         end
      end else if (pk_cmd.step_end && pk_ready) begin
         acc_in = '0;
         cnt_in = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         acc_ff       <= '0;
         cnt_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         acc_ff <= acc_in;
         cnt_ff <= cnt_in;
         if (do_push) begin
            rsp_valid_ff <= 1'b1;
         end else if (!rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         rsp_data_ff <= acc_ff;
         rsp_vb_ff   <= cnt_ff;
         rsp_last_ff <= push_is_end;
         rsp_end_ff  <= push_is_end && pk_cmd.stream_end;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_packed_bytes = rsp_data_ff;
   assign rsp_valid_bytes  = rsp_vb_ff;
   assign rsp_run_last     = rsp_last_ff;
   assign rsp_stream_end   = rsp_end_ff;

endmodule

/* rtl/rle_signed_command_encoder.sv */
// Top level of the run-length encoder: threshold register, literal store,
// sequencer and packer. Depends on rle_enc_pkg, rle_enc_ram, rle_enc_seq,
// rle_enc_pack and rle_signed_command_encoder_defines.svh.
//
//   channel  | handshake          | payload
//   ---------+--------------------+------------------------------------------
//   req      | req_valid/stall    | data_byte[7:0], final_byte
//   rsp      | rsp_valid/stall    | packed_bytes[63:0], valid_bytes[3:0],
//            |                    | run_last, stream_end
//   csr      | csr_wr_en          | wr_data[6:0] (repeat threshold)
//
// A byte that closes no run is taken with no stall. A byte that closes a run
// stalls the input while the sequencer classifies the run, then writes a
// literal run into the store byte by byte and checks for a full chunk, or
// checks for pending literals to flush and sends a repeat pair as a count byte
// and a value byte. Each literal chunk adds a command byte, its data bytes and
// a chunk check; a wrap-up step and a done step close the transaction. A final
// byte also closes the run it leaves open (classify, its work and a further
// wrap-up step), then spends a flush check and an end marker byte. The packer
// takes one byte per cycle while the output is free; output stalls stretch
// each byte and the hand-off. Reset is synchronous and needs no clearing pass.
`include "rle_signed_command_encoder_defines.svh"

module rle_signed_command_encoder #(
   parameter int MAX_RUN   = 127,
   parameter int MAX_CHUNK = 128
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [7:0]  req_data_byte,
   input  logic        req_final_byte,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [63:0] rsp_packed_bytes,
   output logic [3:0]  rsp_valid_bytes,
   output logic        rsp_run_last,
   output logic        rsp_stream_end,
   input  logic        csr_wr_en,
   input  logic [6:0]  csr_wr_data
);

   import rle_enc_pkg::*;

   localparam logic [RUN_W-1:0]  RUN_MAX   = RUN_W'(MAX_RUN);
   localparam logic [LIT_AW-1:0] CHUNK_MAX = LIT_AW'(MAX_CHUNK);

   logic [RUN_W-1:0]  threshold_ff;
   seq_status_type    status;
   pk_cmd_type        pk_cmd;
   logic              pk_ready;
   logic              ram_wr_en;
   logic [LIT_AW-1:0] ram_wr_addr;
   logic [BYTE_W-1:0] ram_wr_data;
   logic              ram_rd_en;
   logic [LIT_AW-1:0] ram_rd_addr;
   logic [BYTE_W-1:0] ram_rd_data;

   always_ff @(posedge clock) begin
      if (reset) begin
         threshold_ff <= THRESH_RESET;
      end else if (csr_wr_en) begin
         threshold_ff <= csr_wr_data;
      end
   end

   assign req_stall = !status.idle;

   rle_enc_ram #(
      .WIDTH (BYTE_W),
      .DEPTH (LIT_DEPTH)
   ) u_store (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_data),
      .rd_en   (ram_rd_en),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_data)
   );

   rle_enc_seq #(
      .MAX_RUN   (MAX_RUN),
      .MAX_CHUNK (MAX_CHUNK)
   ) u_seq (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_data_byte  (req_data_byte),
      .req_final_byte (req_final_byte),
      .threshold      (threshold_ff),
      .status         (status),
      .pk_cmd         (pk_cmd),
      .pk_ready       (pk_ready),
      .ram_wr_en      (ram_wr_en),
      .ram_wr_addr    (ram_wr_addr),
      .ram_wr_data    (ram_wr_data),
      .ram_rd_en      (ram_rd_en),
      .ram_rd_addr    (ram_rd_addr),
      .ram_rd_data    (ram_rd_data)
   );

   rle_enc_pack u_pack (
      .clock            (clock),
      .reset            (reset),
      .pk_cmd           (pk_cmd),
      .pk_ready         (pk_ready),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_packed_bytes (rsp_packed_bytes),
      .rsp_valid_bytes  (rsp_valid_bytes),
      .rsp_run_last     (rsp_run_last),
      .rsp_stream_end   (rsp_stream_end)
   );

   // overflow chunks must drain before the next transaction is taken
   `RLE_ASSERT_IMP(a_idle_below_chunk, clock, reset, status.idle,
      status.pending < CHUNK_MAX, "literals at chunk size left pending while idle")
   `RLE_ASSERT_IMP(a_run_len_max, clock, reset, 1'b1,
      status.run_len <= RUN_MAX, "open run beyond its limit")
   `RLE_ASSERT_IMP(a_end_is_last, clock, reset, rsp_valid && rsp_stream_end,
      rsp_run_last, "end marker result not flagged last")
   `RLE_ASSERT_NXT(a_final_busy, clock, reset,
      req_valid && !req_stall && req_final_byte,
      req_stall, "final byte accepted without flush")

endmodule
